// ===== hw/rtl/lldq_pkg.sv =====
// Shared types and codes for the linked list deque with search.
`default_nettype none

package lldq_pkg;

    // Request codes carried in req_type.
    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_DELETE     = 3'd4,
        REQ_SEARCH     = 3'd5
    } req_t;

    // Status codes carried in status.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Input word.
    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] data_value;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_value;
        logic [8:0]         entry_count;
    } out_word_t;

    // Operation broadcast to every cell.
    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_PUSH_F = 3'd1,
        CMD_PUSH_B = 3'd2,
        CMD_POP_F  = 3'd3,
        CMD_POP_B  = 3'd4,
        CMD_WALK   = 3'd5
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               del;
        logic signed [31:0] data;
    } cell_cmd_t;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic               vld;
        logic signed [31:0] value;
    } slot_t;

    // Walk tokens handed from a cell to the next one toward the tail.
    typedef struct packed {
        logic find;
        logic shift;
    } tok_t;

    // Reply handed from a cell to the next one toward the head.
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic signed [31:0] value;
    } reply_t;

endpackage

`default_nettype wire

// ===== hw/rtl/linked_list_deque_with_search.sv =====
// Top level of the bounded deque with search: controller plus a chain of cells.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_valid / s_ready  | in_word_t  {req_type, data_value}
//  m_      | out | m_valid / m_ready  | out_word_t {status, result_value, entry_count}
//
// Flow: insert front/back and pop front finish in the execute state; pop back
//   waits in the wait state for the reply from the last occupied cell. A search
//   or delete sends a walk token one cell per cycle toward the tail, and the
//   reply moves one cell per cycle back to the head; both also wait until a step
//   counter reaches the entry count, which gives a delete time to close its gap.
//   The next word is taken once the result has gone to the output register.
// Reset clears the cell occupancy bits, tokens, replies and the count at once;
//   there is no clearing pass. One word is worked on at a time.
// Stalls: a finished result waits in the output register; the next word is
//   accepted meanwhile and holds in the done state until the output frees up.
`default_nettype none

module linked_list_deque_with_search #(
    parameter int CAPACITY = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lldq_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lldq_pkg::out_word_t      m_data
);

    // Broadcast command to every cell.
    lldq_pkg::cell_cmd_t cmd;

    // slot[i]: contents of cell i; tok[i]: tokens entering cell i;
    // rep[i]: reply stage of cell i, heading toward cell 0.
    lldq_pkg::slot_t     slot [CAPACITY];
    lldq_pkg::tok_t      tok  [CAPACITY+1];
    lldq_pkg::reply_t    rep  [CAPACITY];

    // The head cell sees the new value to its left, always present.
    lldq_pkg::slot_t     head_in;

    assign head_in = '{vld: 1'b1, value: cmd.data};

    // Start a walk at the head cell.
    assign tok[0] = '{find: (cmd.op == lldq_pkg::CMD_WALK), shift: 1'b0};

    lldq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .head    (slot[0]),
        .rep     (rep[0])
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        lldq_pkg::slot_t  left_s;
        lldq_pkg::slot_t  right_s;
        lldq_pkg::reply_t rep_s;

        // Hook up neighbors; the tail sees an empty cell and no reply beyond it.
        if (i == 0) begin : g_head
            assign left_s = head_in;
        end else begin : g_mid_l
            assign left_s = slot[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_s = '0;
            assign rep_s   = '0;
        end else begin : g_mid_r
            assign right_s = slot[i+1];
            assign rep_s   = rep[i+1];
        end

        lldq_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .is_tail (i == CAPACITY - 1),
            .left    (left_s),
            .right   (right_s),
            .tok_in  (tok[i]),
            .rep_in  (rep_s),
            .here    (slot[i]),
            .tok_out (tok[i+1]),
            .rep_out (rep[i])
        );
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lldq_cell.sv =====
// One storage cell of the deque chain: value, walk tokens and reply stage.
`default_nettype none

module lldq_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lldq_pkg::cell_cmd_t cmd,
    input  wire logic               is_tail,
    input  wire lldq_pkg::slot_t    left,
    input  wire lldq_pkg::slot_t    right,
    input  wire lldq_pkg::tok_t     tok_in,
    input  wire lldq_pkg::reply_t   rep_in,
    output lldq_pkg::slot_t         here,
    output lldq_pkg::tok_t          tok_out,
    output lldq_pkg::reply_t        rep_out
);

    logic               vld_reg, vld_next;
    logic signed [31:0] val_reg, val_next;
    lldq_pkg::tok_t     tok_reg;
    lldq_pkg::reply_t   rep_reg, rep_next;
    lldq_pkg::reply_t   inj;

    always_comb begin
        vld_next = vld_reg;
        val_next = val_reg;
        tok_out  = '0;
        inj      = '0;

        unique case (cmd.op)
            lldq_pkg::CMD_PUSH_F: begin
                vld_next = left.vld;
                val_next = left.value;
            end
            lldq_pkg::CMD_POP_F: begin
                vld_next = right.vld;
                val_next = right.value;
            end
            lldq_pkg::CMD_PUSH_B: begin
                if (!vld_reg && left.vld) begin
                    vld_next = 1'b1;
                    val_next = cmd.data;
                end
            end
            lldq_pkg::CMD_POP_B: begin
                if (vld_reg && !right.vld) begin
                    vld_next = 1'b0;
                    inj      = '{vld: 1'b1, hit: 1'b1, value: val_reg};
                end
            end
            default: ;
        endcase

        // Walk: look for the key, or close the gap left by a delete.
        if (tok_reg.find) begin
            if (!vld_reg) begin
                inj = '{vld: 1'b1, hit: 1'b0, value: '0};
            end else if (val_reg == cmd.data) begin
                inj = '{vld: 1'b1, hit: 1'b1, value: '0};
                if (cmd.del) begin
                    vld_next      = right.vld;
                    val_next      = right.value;
                    tok_out.shift = right.vld;
                end
            end else if (is_tail) begin
                inj = '{vld: 1'b1, hit: 1'b0, value: '0};
            end else begin
                tok_out.find = 1'b1;
            end
        end else if (tok_reg.shift) begin
            vld_next      = right.vld;
            val_next      = right.value;
            tok_out.shift = right.vld;
        end

        rep_next = inj.vld ? inj : rep_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            tok_reg <= '0;
            rep_reg <= '0;
        end else begin
            vld_reg <= vld_next;
            tok_reg <= tok_in;
            rep_reg <= rep_next;
        end
        val_reg <= val_next;
    end

    assign here    = '{vld: vld_reg, value: val_reg};
    assign rep_out = rep_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lldq_ctrl.sv =====
// Request sequencer, entry count and result register of the deque.
`default_nettype none

module lldq_ctrl #(
    parameter int CAPACITY = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire lldq_pkg::in_word_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output lldq_pkg::out_word_t       m_data,
    output lldq_pkg::cell_cmd_t       cmd,
    input  wire lldq_pkg::slot_t      head,
    input  wire lldq_pkg::reply_t     rep
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           req_reg, req_next;
    logic signed [31:0]   key_reg, key_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     step_reg, step_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic                 got_reg, got_next;
    logic [1:0]           status_reg, status_next;
    logic signed [31:0]   res_reg, res_next;
    logic                 out_vld_reg, out_vld_next;
    lldq_pkg::out_word_t  out_reg, out_next;

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        len_next     = len_reg;
        got_next     = got_reg;
        status_next  = status_reg;
        res_next     = res_reg;
        out_vld_next = out_vld_reg && !m_ready;
        out_next     = out_reg;
        cmd.op       = lldq_pkg::CMD_NONE;
        cmd.del      = (req_reg == lldq_pkg::REQ_DELETE);
        cmd.data     = key_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data.req_type;
                    key_next   = s_data.data_value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next = lldq_pkg::ST_EMPTY;
                res_next    = '0;
                step_next   = '0;
                len_next    = '0;
                got_next    = 1'b0;
                state_next  = S_DONE;
                priority if (req_reg == lldq_pkg::REQ_PUSH_FRONT ||
                             req_reg == lldq_pkg::REQ_PUSH_BACK) begin
                    if (count_reg == CNT_W'(CAPACITY)) begin
                        status_next = lldq_pkg::ST_FULL;
                    end else begin
                        cmd.op      = (req_reg == lldq_pkg::REQ_PUSH_FRONT) ?
                                      lldq_pkg::CMD_PUSH_F : lldq_pkg::CMD_PUSH_B;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = lldq_pkg::ST_OK;
                    end
                end else if (count_reg == '0) begin
                    // Empty list: pops, deletes and searches all miss.
                end else if (req_reg == lldq_pkg::REQ_POP_FRONT) begin
                    cmd.op      = lldq_pkg::CMD_POP_F;
                    res_next    = head.value;
                    count_next  = count_reg - CNT_W'(1);
                    status_next = lldq_pkg::ST_OK;
                end else if (req_reg == lldq_pkg::REQ_POP_BACK) begin
                    cmd.op     = lldq_pkg::CMD_POP_B;
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_WAIT;
                end else if (req_reg == lldq_pkg::REQ_DELETE ||
                             req_reg == lldq_pkg::REQ_SEARCH) begin
                    cmd.op     = lldq_pkg::CMD_WALK;
                    len_next   = count_reg;
                    state_next = S_WAIT;
                end else begin
                    // Unknown code: drop it, report a miss.
                end
            end
            S_WAIT: begin
                if (step_reg < len_reg) begin
                    step_next = step_reg + CNT_W'(1);
                end
                if (rep.vld) begin
                    got_next = 1'b1;
                    if (rep.hit) begin
                        status_next = lldq_pkg::ST_OK;
                        if (req_reg == lldq_pkg::REQ_POP_BACK) begin
                            res_next = rep.value;
                        end
                        if (req_reg == lldq_pkg::REQ_DELETE) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end else begin
                        status_next = lldq_pkg::ST_EMPTY;
                    end
                end
                if ((got_reg || rep.vld) && step_reg >= len_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_vld_reg || m_ready) begin
                    out_vld_next          = 1'b1;
                    out_next.status       = status_reg;
                    out_next.result_value = res_reg;
                    out_next.entry_count  = 9'(count_reg);
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            len_reg     <= '0;
            got_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            len_reg     <= len_next;
            got_reg     <= got_next;
            out_vld_reg <= out_vld_next;
        end
        req_reg    <= req_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // A reply only comes back while a pop back or a walk is in flight.
    a_reply_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rep.vld |-> state_reg == S_WAIT)
        else $error("reply from cell chain outside of wait state");

    // The count never runs past the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Between requests the head cell is occupied exactly when the list is not empty.
    a_head_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> (count_reg != '0) == head.vld)
        else $error("head cell occupancy disagrees with entry count");

    // A refused insert leaves the count alone.
    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && count_reg == CNT_W'(CAPACITY) &&
         (req_reg == lldq_pkg::REQ_PUSH_FRONT || req_reg == lldq_pkg::REQ_PUSH_BACK))
        |=> $stable(count_reg))
        else $error("count changed on a refused insert");

endmodule

`default_nettype wire
